@@ design/pnc_pkg.sv @@
// pnc_pkg: shared types, request codes and colour arithmetic for the palette matcher
// no dependencies
package pnc_pkg;

  localparam int CHAN_W  = 8;
  localparam int COLOR_W = 4 * CHAN_W;
  localparam int INDEX_W = 8;
  localparam int SCORE_W = CHAN_W + 2;

  typedef logic [1:0]         action_t;
  typedef logic [CHAN_W-1:0]  chan_t;
  typedef logic [COLOR_W-1:0] color_t;
  typedef logic [INDEX_W-1:0] index_t;

  localparam action_t ACT_LOAD  = 2'd0;
  localparam action_t ACT_MATCH = 2'd1;
  localparam action_t ACT_BLEND = 2'd2;

  // sum of absolute channel differences, divided by four
  function automatic chan_t pnc_score(input color_t a, input color_t b);
    logic [SCORE_W-1:0] sum;
    chan_t x;
    chan_t y;
    sum = '0;
    for (int c = 0; c < 4; c++) begin
      x   = a[CHAN_W*c +: CHAN_W];
      y   = b[CHAN_W*c +: CHAN_W];
      sum = sum + SCORE_W'((x > y) ? (x - y) : (y - x));
    end
    return sum[SCORE_W-1:2];
  endfunction

  // per channel sum of the two halved values
  function automatic color_t pnc_mix(input color_t a, input color_t b);
    color_t m;
    chan_t  x;
    chan_t  y;
    m = '0;
    for (int c = 0; c < 4; c++) begin
      x = a[CHAN_W*c +: CHAN_W];
      y = b[CHAN_W*c +: CHAN_W];
      m[CHAN_W*c +: CHAN_W] = (x >> 1) + (y >> 1);
    end
    return m;
  endfunction

endpackage

@@ design/palette_nearest_color_match.sv @@
// palette_nearest_color_match: rgba palette store with a sequential nearest-colour search
// depends on pnc_pkg
//
// A load request writes one palette entry in the cycle it is taken and leaves the block
// free. A match request runs one difference-and-compare unit over every entry, one entry
// a cycle from the palette memory, so busy stays high through ST_SCAN and ST_FLUSH and the
// answer appears with out_valid for one cycle as busy falls. A blend request first reads
// its two entries, then mixes them. The receiver cannot stall: out_best_index must be
// taken in the cycle out_valid is high. Entries never loaded since reset read as zero.
module palette_nearest_color_match #(
  parameter int PALETTE_SIZE = 256
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  pnc_pkg::action_t in_action,
  input  pnc_pkg::index_t in_first_index,
  input  pnc_pkg::index_t in_second_index,
  input  pnc_pkg::chan_t  in_red,
  input  pnc_pkg::chan_t  in_green,
  input  pnc_pkg::chan_t  in_blue,
  input  pnc_pkg::chan_t  in_alpha,
  output logic            out_valid,
  output pnc_pkg::index_t out_best_index
);
  import pnc_pkg::*;

  localparam int AW = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(PALETTE_SIZE - 1);
  localparam logic [INDEX_W:0] SIZE_EXT = (INDEX_W + 1)'(PALETTE_SIZE);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BLEND_A,
    ST_BLEND_B,
    ST_BLEND_MIX,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  state_t state_r;

  color_t              mem [PALETTE_SIZE];
  logic [PALETTE_SIZE-1:0] valid_r;
  color_t              rd_data_r;
  logic                rd_ok_r;

  color_t              color_r;
  color_t              blend_a_r;
  index_t              first_r;
  index_t              second_r;
  logic [AW-1:0]       idx_r;
  logic                cmp_valid_r;
  logic [AW-1:0]       cmp_idx_r;
  chan_t               best_score_r;
  logic [AW-1:0]       best_idx_r;
  logic                out_valid_r;
  index_t              out_best_index_r;

  logic                accept;
  logic                we;
  logic [AW-1:0]       wr_addr;
  color_t              in_color;
  logic [AW-1:0]       rd_addr;
  logic                rd_in_range;
  color_t              entry;
  chan_t               score;
  logic                take;
  logic [AW-1:0]       best_idx_nxt;

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign in_color  = {in_alpha, in_blue, in_green, in_red};
  assign wr_addr   = in_first_index[AW-1:0];
  assign we        = accept && (in_action == ACT_LOAD) && ({1'b0, in_first_index} < SIZE_EXT);

  always_comb begin
    rd_addr     = idx_r;
    rd_in_range = 1'b1;
    unique case (state_r)
      ST_BLEND_A: begin
        rd_in_range = ({1'b0, first_r} < SIZE_EXT);
        rd_addr     = rd_in_range ? first_r[AW-1:0] : '0;
      end
      ST_BLEND_B: begin
        rd_in_range = ({1'b0, second_r} < SIZE_EXT);
        rd_addr     = rd_in_range ? second_r[AW-1:0] : '0;
      end
      ST_IDLE, ST_BLEND_MIX, ST_SCAN, ST_FLUSH: begin
        rd_addr     = idx_r;
        rd_in_range = 1'b1;
      end
      default: begin
        rd_addr     = idx_r;
        rd_in_range = 1'b1;
      end
    endcase
  end

  // palette memory, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= in_color;
    end
    rd_data_r <= mem[rd_addr];
  end

  // compare stage
  assign entry        = rd_ok_r ? rd_data_r : '0;
  assign score        = pnc_score(entry, color_r);
  assign take         = cmp_valid_r && ((cmp_idx_r == '0) || (score < best_score_r));
  assign best_idx_nxt = take ? cmp_idx_r : best_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      rd_ok_r     <= 1'b0;
      cmp_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      rd_ok_r     <= rd_in_range && valid_r[rd_addr];
      cmp_valid_r <= (state_r == ST_SCAN);
      cmp_idx_r   <= idx_r;
      out_valid_r <= 1'b0;
      if (we) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (take) begin
        best_score_r <= score;
        best_idx_r   <= cmp_idx_r;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            first_r  <= in_first_index;
            second_r <= in_second_index;
            color_r  <= in_color;
            idx_r    <= '0;
            if (in_action == ACT_MATCH) begin
              state_r <= ST_SCAN;
            end else if (in_action == ACT_BLEND) begin
              state_r <= ST_BLEND_A;
            end
          end
        end
        ST_BLEND_A: begin
          state_r <= ST_BLEND_B;
        end
        ST_BLEND_B: begin
          blend_a_r <= entry;
          state_r   <= ST_BLEND_MIX;
        end
        ST_BLEND_MIX: begin
          color_r <= pnc_mix(blend_a_r, entry);
          idx_r   <= '0;
          state_r <= ST_SCAN;
        end
        ST_SCAN: begin
          if (idx_r == LAST_IDX) begin
            state_r <= ST_FLUSH;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        ST_FLUSH: begin
          out_valid_r      <= 1'b1;
          out_best_index_r <= INDEX_W'(best_idx_nxt);
          state_r          <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_best_index = out_best_index_r;

  a_out_after_flush: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == ST_FLUSH))
    else $error("result strobe without a finished scan");

  a_load_stays_free: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_action == ACT_LOAD)) |=> !busy)
    else $error("load request left the block busy");

  a_scan_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && idx_r == LAST_IDX) |=> (state_r == ST_FLUSH))
    else $error("scan did not end after the last entry");

  a_compare_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |=> cmp_valid_r)
    else $error("compare stage missed a scanned entry");

endmodule

@@ bench/testbench.sv @@
// testbench: self-checking bench for palette_nearest_color_match, a palette scoreboard
// predicts each best index from its own palette copy and checks every out_best_index
// depends on pnc_pkg and palette_nearest_color_match
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import pnc_pkg::*;

  localparam int ENTRIES = 256;
  localparam int RANDOM_REQUESTS = 650;
  localparam int DRAIN_CYCLES = 300;
  localparam action_t ACT_UNUSED = 2'd3;

  class palette_scoreboard;
    color_t palette [ENTRIES];
    index_t expected_index [$];
    int errors;
    int checked;

    function new();
      foreach (palette[i]) palette[i] = '0;
      errors = 0;
      checked = 0;
    endfunction

    // lowest index with the smallest quarter sum of channel differences
    function index_t nearest_entry(color_t color);
      int best;
      int best_gap;
      int gap;
      int x;
      int y;
      best = 0;
      best_gap = 0;
      for (int i = 0; i < ENTRIES; i++) begin
        gap = 0;
        for (int c = 0; c < 4; c++) begin
          x = palette[i][8*c +: 8];
          y = color[8*c +: 8];
          gap += (x > y) ? x - y : y - x;
        end
        gap = gap >> 2;
        if (i == 0 || gap < best_gap) begin
          best = i;
          best_gap = gap;
        end
      end
      return index_t'(best);
    endfunction

    function void note_request(action_t act, index_t first, index_t second, color_t color);
      color_t a;
      color_t b;
      color_t mix;
      case (act)
        ACT_LOAD: begin
          if (first < ENTRIES) palette[first] = color;
        end
        ACT_MATCH: begin
          expected_index.push_back(nearest_entry(color));
        end
        ACT_BLEND: begin
          a = (first < ENTRIES) ? palette[first] : '0;
          b = (second < ENTRIES) ? palette[second] : '0;
          for (int c = 0; c < 4; c++) mix[8*c +: 8] = (a[8*c +: 8] >> 1) + (b[8*c +: 8] >> 1);
          expected_index.push_back(nearest_entry(mix));
        end
        default: begin
        end
      endcase
    endfunction

    function void check_result(index_t actual);
      index_t want;
      if (expected_index.size() == 0) begin
        $error("out_best_index: expected none, actual %0d", actual);
        errors++;
      end else begin
        want = expected_index.pop_front();
        checked++;
        if (actual !== want) begin
          $error("out_best_index: expected %0d, actual %0d", want, actual);
          errors++;
        end
      end
    endfunction
  endclass

  logic    clk;
  logic    rst_n;
  logic    start;
  logic    busy;
  action_t in_action;
  index_t  in_first_index;
  index_t  in_second_index;
  chan_t   in_red;
  chan_t   in_green;
  chan_t   in_blue;
  chan_t   in_alpha;
  logic    out_valid;
  index_t  out_best_index;

  palette_scoreboard sb = new();
  bit quiet;
  int load_count;
  int match_count;
  int blend_count;
  int unused_count;

  palette_nearest_color_match #(
    .PALETTE_SIZE(ENTRIES)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_action(in_action),
    .in_first_index(in_first_index),
    .in_second_index(in_second_index),
    .in_red(in_red),
    .in_green(in_green),
    .in_blue(in_blue),
    .in_alpha(in_alpha),
    .out_valid(out_valid),
    .out_best_index(out_best_index)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) sb.check_result(out_best_index);
  end

  // called at a falling edge, returns at the falling edge after the request is taken
  task automatic send_request(input action_t act, input index_t first, input index_t second,
                              input color_t color);
    bit hold;
    in_action       <= act;
    in_first_index  <= first;
    in_second_index <= second;
    {in_alpha, in_blue, in_green, in_red} <= color;
    forever begin
      hold = !quiet && $urandom_range(99) < 19;
      start <= !hold;
      @(posedge clk);
      if (!hold && busy === 1'b0) break;
      @(negedge clk);
    end
    sb.note_request(act, first, second, color);
    case (act)
      ACT_LOAD:  load_count++;
      ACT_MATCH: match_count++;
      ACT_BLEND: blend_count++;
      default:   unused_count++;
    endcase
    @(negedge clk);
  endtask

  function automatic chan_t pick_chan();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hff;
      default: return chan_t'($urandom_range(255));
    endcase
  endfunction

  function automatic color_t pick_color();
    return {pick_chan(), pick_chan(), pick_chan(), pick_chan()};
  endfunction

  // crowded low indices make duplicates and ties likely
  function automatic index_t pick_index();
    if ($urandom_range(99) < 50) return index_t'($urandom_range(15));
    return index_t'($urandom_range(255));
  endfunction

  // a palette colour nudged by a few steps per channel, clamped to the channel range
  function automatic color_t near_color(color_t base);
    color_t c;
    int v;
    for (int k = 0; k < 4; k++) begin
      v = int'(base[8*k +: 8]) + $urandom_range(12) - 6;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      c[8*k +: 8] = v[7:0];
    end
    return c;
  endfunction

  initial begin
    int counted;
    int roll;
    action_t act;
    index_t first;
    color_t color;

    rst_n = 1'b0;
    start = 1'b0;
    in_action = ACT_LOAD;
    in_first_index = '0;
    in_second_index = '0;
    in_red = '0;
    in_green = '0;
    in_blue = '0;
    in_alpha = '0;
    quiet = 1'b0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // cleared palette, extremes, ties and ignored fields
    send_request(ACT_MATCH, 8'h00, 8'h00, 32'h0000_0000);
    send_request(ACT_MATCH, 8'hff, 8'hff, 32'hffff_ffff);
    send_request(ACT_BLEND, 8'h00, 8'hff, 32'hffff_ffff);
    send_request(ACT_UNUSED, 8'hff, 8'hff, 32'hffff_ffff);
    send_request(ACT_LOAD, 8'hff, 8'hff, 32'hffff_ffff);
    send_request(ACT_LOAD, 8'h80, 8'h00, 32'h8080_8080);
    send_request(ACT_LOAD, 8'h02, 8'h00, 32'h0000_0003);
    send_request(ACT_LOAD, 8'h01, 8'h00, 32'h0000_00ff);
    send_request(ACT_LOAD, 8'h03, 8'h00, 32'h0000_ff00);
    send_request(ACT_LOAD, 8'h04, 8'h00, 32'h00ff_0000);
    send_request(ACT_LOAD, 8'h05, 8'h00, 32'hff00_0000);
    send_request(ACT_MATCH, 8'h00, 8'h00, 32'h0000_0000);
    send_request(ACT_MATCH, 8'h00, 8'h00, 32'h0000_00ff);
    send_request(ACT_MATCH, 8'h00, 8'h00, 32'h0000_ff00);
    send_request(ACT_MATCH, 8'h00, 8'h00, 32'h00ff_0000);
    send_request(ACT_MATCH, 8'h00, 8'h00, 32'hff00_0000);
    send_request(ACT_MATCH, 8'h00, 8'h00, 32'hffff_ffff);
    send_request(ACT_MATCH, 8'h00, 8'h00, 32'h7f7f_7f7f);
    send_request(ACT_BLEND, 8'hff, 8'hff, 32'h0000_0000);
    send_request(ACT_BLEND, 8'h00, 8'hff, 32'h0000_0000);
    send_request(ACT_BLEND, 8'h01, 8'h03, 32'h1234_5678);
    send_request(ACT_LOAD, 8'h80, 8'haa, 32'h0102_0304);
    send_request(ACT_MATCH, 8'h80, 8'h55, 32'h8080_8080);
    send_request(ACT_UNUSED, 8'h00, 8'h00, 32'h0000_0000);

    counted = 0;
    while (counted < RANDOM_REQUESTS) begin
      quiet = counted >= 200 && counted < 320;
      roll = $urandom_range(99);
      if (roll < 40) act = ACT_LOAD;
      else if (roll < 70) act = ACT_MATCH;
      else if (roll < 95) act = ACT_BLEND;
      else act = ACT_UNUSED;
      first = pick_index();
      case ($urandom_range(3))
        0:       color = sb.palette[pick_index()];
        1:       color = near_color(sb.palette[pick_index()]);
        default: color = pick_color();
      endcase
      send_request(act, first, index_t'($urandom_range(255)), color);
      if (act != ACT_UNUSED) counted++;
    end
    start <= 1'b0;

    while (sb.expected_index.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("requests taken: %0d loads, %0d matches, %0d blends, %0d with the unused action",
             load_count, match_count, blend_count, unused_count);
    $display("best indices compared: %0d, mismatches: %0d", sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("testbench NOT OK");
    $finish;
  end

endmodule

@@ palette_nearest_color_match.f @@
design/pnc_pkg.sv
design/palette_nearest_color_match.sv
bench/testbench.sv
